/* sv/ssi_pkg.sv */
// Shared widths, word types and queue constants for the segment/sphere intersect block.
package ssi_pkg;

  localparam int COORD_BITS  = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int RADIUS_BITS = 15;

  localparam int DIFF_W  = COORD_BITS + 1;     // S-C and E-S
  localparam int PROD_W  = 2 * DIFF_W;         // one coordinate product
  localparam int MAG_W   = 2 * COORD_BITS + 2; // sum of three products, magnitude
  localparam int HALF_W  = MAG_W / 2;          // split for the wide squares
  localparam int H_W     = MAG_W + 1;          // X.Y, signed
  localparam int C_W     = MAG_W + 1;          // X.X - r*r, signed
  localparam int RR_W    = 2 * RADIUS_BITS;
  localparam int SQ_W    = 2 * MAG_W;          // h*h and a*c magnitude
  localparam int D_W     = SQ_W + 2;           // discriminant when not negative
  localparam int ROOT_W  = MAG_W + 1;          // floor sqrt of the discriminant
  localparam int TWO_A_W = MAG_W + 1;
  localparam int NB_W    = MAG_W + 3;          // -b, signed
  localparam int T_W     = T_FRAC_BITS + 1;
  localparam int REM_W   = TWO_A_W + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  start_z;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic signed [COORD_BITS-1:0]  end_z;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic signed [COORD_BITS-1:0]  center_z;
    logic        [RADIUS_BITS-1:0] radius;
  } in_word_t;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] t_fraction;
  } out_word_t;

  // Classified query handed from front to back.
  typedef struct packed {
    logic                     miss;
    logic [D_W-1:0]           d;
    logic signed [NB_W-1:0]   nb;
    logic [TWO_A_W-1:0]       two_a;
  } qent_t;

endpackage

/* sv/ssi_front.sv */
// Front pipeline: forms a, b, c and the discriminant, classifies the query.
module ssi_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ssi_pkg::in_word_t in_word_i,
  input  logic             full_i,
  output logic             push_o,
  output ssi_pkg::qent_t   entry_o
);
  import ssi_pkg::*;

  localparam int NST = 6;

  logic [NST-1:0] v_q;
  logic           en;

  // stage 0
  logic signed [COORD_BITS-1:0] sp [3];
  logic signed [COORD_BITS-1:0] ep [3];
  logic signed [COORD_BITS-1:0] cp [3];
  logic signed [DIFF_W-1:0]     x_q [3];
  logic signed [DIFF_W-1:0]     y_q [3];
  logic [RADIUS_BITS-1:0]       r_q;
  // stage 1
  logic signed [PROD_W-1:0]     yy_q [3];
  logic signed [PROD_W-1:0]     xy_q [3];
  logic signed [PROD_W-1:0]     xx_q [3];
  logic [RR_W-1:0]              rr_q;
  // stage 2
  logic signed [MAG_W:0]        a_sum, xx_sum;
  logic [MAG_W-1:0]             a_q;
  logic signed [H_W-1:0]        h_q;
  logic signed [C_W-1:0]        c_q;
  // stage 3
  logic signed [H_W-1:0]        h_abs_s;
  logic signed [C_W-1:0]        c_abs_s;
  logic [MAG_W-1:0]             h_abs, c_abs;
  logic signed [NB_W-1:0]       h_ext;
  logic [2*HALF_W-1:0]          phh_q, phl_q, pll_q;
  logic [2*HALF_W-1:0]          qhh_q, qhl_q, qlh_q, qll_q;
  logic                         c_neg3_q, a_zero3_q;
  logic signed [NB_W-1:0]       nb3_q;
  logic [TWO_A_W-1:0]           two_a3_q;
  // stage 4
  logic [SQ_W-1:0]              h2_q, ac_q;
  logic                         c_neg4_q, a_zero4_q;
  logic signed [NB_W-1:0]       nb4_q;
  logic [TWO_A_W-1:0]           two_a4_q;
  // stage 5
  logic signed [SQ_W:0]         sac, dd;
  qent_t                        ent_q;

  assign en         = !(v_q[NST-1] && full_i);
  assign in_stall_o = !en;
  assign push_o     = v_q[NST-1] && !full_i;
  assign entry_o    = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  assign sp[0] = in_word_i.start_x;
  assign sp[1] = in_word_i.start_y;
  assign sp[2] = in_word_i.start_z;
  assign ep[0] = in_word_i.end_x;
  assign ep[1] = in_word_i.end_y;
  assign ep[2] = in_word_i.end_z;
  assign cp[0] = in_word_i.center_x;
  assign cp[1] = in_word_i.center_y;
  assign cp[2] = in_word_i.center_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        x_q[k]  <= DIFF_W'(sp[k]) - DIFF_W'(cp[k]);
        y_q[k]  <= DIFF_W'(ep[k]) - DIFF_W'(sp[k]);
        yy_q[k] <= y_q[k] * y_q[k];
        xy_q[k] <= x_q[k] * y_q[k];
        xx_q[k] <= x_q[k] * x_q[k];
      end
      r_q  <= in_word_i.radius;
      rr_q <= r_q * r_q;
    end
  end

  always_comb begin
    a_sum  = (MAG_W+1)'(yy_q[0]) + (MAG_W+1)'(yy_q[1]) + (MAG_W+1)'(yy_q[2]);
    xx_sum = (MAG_W+1)'(xx_q[0]) + (MAG_W+1)'(xx_q[1]) + (MAG_W+1)'(xx_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_sum[MAG_W-1:0];
      h_q <= H_W'(xy_q[0]) + H_W'(xy_q[1]) + H_W'(xy_q[2]);
      c_q <= C_W'(xx_sum) - $signed(C_W'(rr_q));
    end
  end

  // stage 3: split the wide squares into narrow partial products
  always_comb begin
    h_abs_s = h_q[H_W-1] ? -h_q : h_q;
    c_abs_s = c_q[C_W-1] ? -c_q : c_q;
    h_abs   = h_abs_s[MAG_W-1:0];
    c_abs   = c_abs_s[MAG_W-1:0];
    h_ext   = NB_W'(h_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phh_q     <= h_abs[MAG_W-1:HALF_W] * h_abs[MAG_W-1:HALF_W];
      phl_q     <= h_abs[MAG_W-1:HALF_W] * h_abs[HALF_W-1:0];
      pll_q     <= h_abs[HALF_W-1:0] * h_abs[HALF_W-1:0];
      qhh_q     <= a_q[MAG_W-1:HALF_W] * c_abs[MAG_W-1:HALF_W];
      qhl_q     <= a_q[MAG_W-1:HALF_W] * c_abs[HALF_W-1:0];
      qlh_q     <= a_q[HALF_W-1:0] * c_abs[MAG_W-1:HALF_W];
      qll_q     <= a_q[HALF_W-1:0] * c_abs[HALF_W-1:0];
      c_neg3_q  <= c_q[C_W-1];
      a_zero3_q <= (a_q == '0);
      nb3_q     <= -(h_ext <<< 1);
      two_a3_q  <= {a_q, 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h2_q <= (SQ_W'(phh_q) << (2*HALF_W)) + (SQ_W'(phl_q) << (HALF_W+1)) + SQ_W'(pll_q);
      ac_q <= (SQ_W'(qhh_q) << (2*HALF_W)) + ((SQ_W'(qhl_q) + SQ_W'(qlh_q)) << HALF_W)
              + SQ_W'(qll_q);
      c_neg4_q  <= c_neg3_q;
      a_zero4_q <= a_zero3_q;
      nb4_q     <= nb3_q;
      two_a4_q  <= two_a3_q;
    end
  end

  // d = 4 * (h*h - a*c)
  always_comb begin
    sac = c_neg4_q ? -$signed({1'b0, ac_q}) : $signed({1'b0, ac_q});
    dd  = $signed({1'b0, h2_q}) - sac;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q.miss  <= a_zero4_q || dd[SQ_W];
      ent_q.d     <= {dd[SQ_W-1:0], 2'b00};
      ent_q.nb    <= nb4_q;
      ent_q.two_a <= two_a4_q;
    end
  end

endmodule

/* sv/ssi_fifo.sv */
// Short queue between the front and back pipelines.
module ssi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssi_pkg::qent_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output ssi_pkg::qent_t entry_o,
  output logic           empty_o
);
  import ssi_pkg::*;

  qent_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count slip");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_q == QPTR_W'(rd_q + cnt_q[QPTR_W-1:0])) else $error("queue pointers disagree");
`endif

endmodule

/* sv/ssi_back.sv */
// Back pipeline: bit-serial square root, root pick and restoring divide for t.
module ssi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  output logic              pop_o,
  input  ssi_pkg::qent_t    entry_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssi_pkg::out_word_t out_word_o
);
  import ssi_pkg::*;

  localparam int WW = D_W + 1;
  localparam int NW = NB_W + 1;

  logic en;

  // square-root stages
  logic                   sq_v_q    [ROOT_W+1];
  logic [WW-1:0]          sq_rem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]      sq_root_q [ROOT_W+1];
  logic                   sq_miss_q [ROOT_W+1];
  logic signed [NB_W-1:0] sq_nb_q   [ROOT_W+1];
  logic [TWO_A_W-1:0]     sq_ta_q   [ROOT_W+1];

  // divide stages, entry 0 is the root pick
  logic                   dv_v_q   [T_W+1];
  logic [REM_W-1:0]       dv_rem_q [T_W+1];
  logic [T_W-1:0]         dv_quo_q [T_W+1];
  logic [TWO_A_W-1:0]     dv_den_q [T_W+1];
  logic                   dv_hit_q [T_W+1];

  logic signed [NW-1:0]   n1, n2, ta_s, nb_s, s_s;
  logic                   u1, u2;

  assign en    = !(dv_v_q[T_W] && out_stall_i);
  assign pop_o = en && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_rem_q[0]  <= WW'(entry_i.d);
      sq_root_q[0] <= '0;
      sq_miss_q[0] <= entry_i.miss;
      sq_nb_q[0]   <= entry_i.nb;
      sq_ta_q[0]   <= entry_i.two_a;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam int I = ROOT_W - 1 - k;
    logic [WW-1:0] term;
    logic          take;
    assign term = (WW'(sq_root_q[k]) << (I + 1)) + (WW'(1) << (2 * I));
    assign take = (sq_rem_q[k] >= term);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_rem_q[k+1]  <= take ? sq_rem_q[k] - term : sq_rem_q[k];
        sq_root_q[k+1] <= sq_root_q[k] | (take ? (ROOT_W'(1) << I) : '0);
        sq_miss_q[k+1] <= sq_miss_q[k];
        sq_nb_q[k+1]   <= sq_nb_q[k];
        sq_ta_q[k+1]   <= sq_ta_q[k];
      end
    end
  end

  // nearer root first, farther root if the nearer one is off the segment
  always_comb begin
    nb_s = NW'(sq_nb_q[ROOT_W]);
    s_s  = NW'($signed({1'b0, sq_root_q[ROOT_W]}));
    ta_s = NW'($signed({1'b0, sq_ta_q[ROOT_W]}));
    n1   = nb_s - s_s;
    n2   = nb_s + s_s;
    u1   = !n1[NW-1] && (n1 <= ta_s);
    u2   = !n2[NW-1] && (n2 <= ta_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_hit_q[0] <= !sq_miss_q[ROOT_W] && (u1 || u2);
      dv_rem_q[0] <= (sq_miss_q[ROOT_W] || !(u1 || u2)) ? '0 :
                     u1 ? REM_W'(n1[TWO_A_W-1:0]) : REM_W'(n2[TWO_A_W-1:0]);
      dv_den_q[0] <= sq_ta_q[ROOT_W];
      dv_quo_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < T_W; j++) begin : g_div
    logic [REM_W-1:0] r;
    logic             ge;
    assign r  = (j == 0) ? dv_rem_q[j] : (dv_rem_q[j] << 1);
    assign ge = (r >= REM_W'(dv_den_q[j]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[j+1] <= ge ? r - REM_W'(dv_den_q[j]) : r;
        dv_quo_q[j+1] <= {dv_quo_q[j][T_W-2:0], ge};
        dv_den_q[j+1] <= dv_den_q[j];
        dv_hit_q[j+1] <= dv_hit_q[j];
      end
    end
  end

  always_comb begin
    out_valid_o           = dv_v_q[T_W];
    out_word_o.hit        = dv_hit_q[T_W];
    out_word_o.t_fraction = dv_hit_q[T_W] ? dv_quo_q[T_W] : '0;
  end

endmodule

/* sv/segment_sphere_intersect.sv */
// Top level of the segment/sphere intersect block: front, queue, back.
//
// Usage:
//  - Input channel in_valid_i / in_stall_o / in_word_i carries one query word:
//    segment start and end, sphere center (signed) and radius (unsigned).
//  - Output channel out_valid_o / out_stall_i / out_word_o returns one result
//    word per query, in order: hit flag and t in Q1.16 (65536 = end point,
//    0 on a miss, zero-length segment or negative discriminant).
//  - A word moves on a rising edge where valid is high and stall is low.
//  - Throughput: one query per cycle, sustained while the output is not stalled.
//  - Pipeline from input accept to output accept, with no stalls:
//    6 front stages, one queue slot, one square-root load stage, 35
//    square-root steps (one result bit each), one root-pick stage, 17 divide
//    steps (one t bit each).
//  - A stalled output freezes the back pipeline; the 4-word queue keeps
//    taking finished front work, and the front stalls its input only once
//    the queue is full and its last stage holds a word.
//  - Reset (rst_ni low, asynchronous) empties all pipelines and the queue;
//    no configuration, no clearing pass, input is taken right after reset.
module segment_sphere_intersect (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ssi_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ssi_pkg::out_word_t  out_word_o
);
  import ssi_pkg::*;

  logic  q_push, q_full;
  logic  q_pop, q_empty;
  qent_t f_entry, b_entry;

  ssi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (f_entry)
  );

  ssi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (f_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (b_entry),
    .empty_o (q_empty)
  );

  ssi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .pop_o       (q_pop),
    .entry_i     (b_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
